### rtl/megm_pkg.sv
package megm_pkg;

  localparam int GRID_ROWS = 16;
  localparam int GRID_COLS = 32;
  localparam int CELLS     = GRID_ROWS * GRID_COLS;
  localparam int ADDR_W    = $clog2(CELLS);

  localparam int ROW_W   = 4;
  localparam int COL_W   = 5;
  localparam int LEVEL_W = 10;
  localparam int TIME_W  = 16;
  localparam int MARK_W  = 8;
  localparam int MOVE_W  = 6;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 16;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [CIDX_W-1:0] CFG_SIDE_THR   = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_FWD_THR    = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_FIN_THR    = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_SEG_TIME   = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_START_ROW  = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_START_COL  = 3'd5;
  localparam logic [CIDX_W-1:0] CFG_START_HEAD = 3'd6;

  localparam logic [LEVEL_W-1:0] RST_SIDE_THR = 10'd100;
  localparam logic [LEVEL_W-1:0] RST_FWD_THR  = 10'd200;
  localparam logic [LEVEL_W-1:0] RST_FIN_THR  = 10'd600;
  localparam logic [TIME_W-1:0]  RST_SEG_TIME = 16'd390;
  localparam logic [ROW_W-1:0]   RST_START_ROW  = 4'd2;
  localparam logic [COL_W-1:0]   RST_START_COL  = 5'd0;
  localparam logic [1:0]         RST_START_HEAD = 2'd1;

  localparam logic [1:0] HEAD_NORTH = 2'd0;
  localparam logic [1:0] HEAD_EAST  = 2'd1;
  localparam logic [1:0] HEAD_SOUTH = 2'd2;
  localparam logic [1:0] HEAD_WEST  = 2'd3;

  localparam logic [MARK_W-1:0] MARK_DEAD = 8'd255;
  localparam logic [MARK_W-1:0] MARK_MAX  = 8'd254;

  typedef enum logic [1:0] {
    TURN_STRAIGHT = 2'd0,
    TURN_RIGHT    = 2'd1,
    TURN_BACK     = 2'd2,
    TURN_LEFT     = 2'd3
  } turn_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FINISH  = 2'd1,
    STAT_OFFGRID = 2'd2,
    STAT_IGNORED = 2'd3
  } stat_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_WALK,
    ST_DECIDE,
    ST_LOOK,
    ST_CHECK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0] elapsed;
    logic              finish;
    turn_t             turn;
  } megm_item_t;

  typedef struct packed {
    logic             ld_row;
    logic             ld_col;
    logic             ld_head;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [1:0]       head;
  } megm_ld_t;

  function automatic logic [ROW_W-1:0] clamp_row(input logic [ROW_W-1:0] r);
    return (int'(r) < GRID_ROWS) ? r : ROW_W'(GRID_ROWS - 1);
  endfunction

  function automatic logic [COL_W-1:0] clamp_col(input logic [COL_W-1:0] c);
    return (int'(c) < GRID_COLS) ? c : COL_W'(GRID_COLS - 1);
  endfunction

endpackage

### rtl/megm_ram.sv
module megm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/megm_front.sv
module megm_front
  import megm_pkg::*;
(
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [TIME_W-1:0]  in_elapsed_ms,
  input  logic [LEVEL_W-1:0] in_far_left_level,
  input  logic [LEVEL_W-1:0] in_far_right_level,
  input  logic [LEVEL_W-1:0] in_mid_left_level,
  input  logic [LEVEL_W-1:0] in_center_level,
  input  logic [LEVEL_W-1:0] in_mid_right_level,
  input  logic [LEVEL_W-1:0] side_thr,
  input  logic [LEVEL_W-1:0] fwd_thr,
  input  logic [LEVEL_W-1:0] fin_thr,
  input  logic               clearing,
  input  logic               q_full,
  output logic               q_push,
  output megm_item_t         q_item
);

  logic left_open;
  logic fwd_open;
  logic right_open;

  assign in_stall = clearing | q_full;
  assign q_push   = in_valid & ~in_stall;

  assign left_open  = in_far_left_level > side_thr;
  assign right_open = in_far_right_level > side_thr;
  assign fwd_open   = (in_mid_left_level > fwd_thr) | (in_center_level > fwd_thr) |
                      (in_mid_right_level > fwd_thr);

  always_comb begin
    q_item.elapsed = in_elapsed_ms;
    q_item.finish  = (in_mid_left_level > fin_thr) & (in_center_level > fin_thr) &
                     (in_mid_right_level > fin_thr);
    if (left_open) begin
      q_item.turn = TURN_LEFT;
    end else if (fwd_open) begin
      q_item.turn = TURN_STRAIGHT;
    end else if (right_open) begin
      q_item.turn = TURN_RIGHT;
    end else begin
      q_item.turn = TURN_BACK;
    end
  end

endmodule

### rtl/megm_queue.sv
module megm_queue
  import megm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  megm_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output megm_item_t pop_item
);

  megm_item_t        ent_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_pop;

  assign full     = (int'(cnt_r) == QDEPTH);
  assign empty    = (cnt_r == '0);
  assign pop_item = ent_r[rd_ptr_r];
  assign do_pop   = pop & ~empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (int'(wr_ptr_r) == QDEPTH - 1) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (int'(rd_ptr_r) == QDEPTH - 1) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### rtl/megm_back.sv
module megm_back
  import megm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  megm_ld_t          ld,
  input  logic [TIME_W-1:0] seg_time,
  input  logic              q_empty,
  input  megm_item_t        q_item,
  output logic              q_pop,
  output logic              clearing,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ROW_W-1:0]  out_row_now,
  output logic [COL_W-1:0]  out_col_now,
  output logic [1:0]        out_heading_now,
  output logic [1:0]        out_chosen_turn,
  output logic [MOVE_W-1:0] out_cells_advanced,
  output logic [1:0]        out_status
);

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  megm_item_t        item_r, item_nxt;
  logic [TIME_W-1:0] rem_r, rem_nxt;
  logic [TIME_W-1:0] quo_r, quo_nxt;
  logic [3:0]        div_cnt_r, div_cnt_nxt;
  logic [TIME_W-1:0] steps_r, steps_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [1:0]        head_r, head_nxt;
  logic [MARK_W-1:0] vc_r, vc_nxt;
  logic              bt_r, bt_nxt;
  logic              done_r, done_nxt;
  logic [MOVE_W-1:0] moved_r, moved_nxt;
  stat_t             status_r, status_nxt;
  turn_t             turn_r, turn_nxt;

  logic              ov_r, ov_nxt;
  logic [ROW_W-1:0]  o_row_r, o_row_nxt;
  logic [COL_W-1:0]  o_col_r, o_col_nxt;
  logic [1:0]        o_head_r, o_head_nxt;
  turn_t             o_turn_r, o_turn_nxt;
  logic [MOVE_W-1:0] o_moved_r, o_moved_nxt;
  stat_t             o_status_r, o_status_nxt;

  logic              ahead_ok;
  logic [ROW_W-1:0]  ahead_row;
  logic [COL_W-1:0]  ahead_col;
  logic [ADDR_W-1:0] ahead_addr;
  logic [ADDR_W-1:0] pos_addr;
  logic [MARK_W-1:0] inc_vc;
  logic [MARK_W-1:0] mark_vc;
  logic [MARK_W-1:0] mark_val;
  logic [MOVE_W-1:0] moved_inc;
  logic [TIME_W:0]   rem_sh;
  logic              rem_ge;
  logic [TIME_W-1:0] quo_new;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [MARK_W-1:0] ram_wdata;
  logic [MARK_W-1:0] ram_rdata;
  logic              emit_go;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    return ADDR_W'(int'(r) * GRID_COLS + int'(c));
  endfunction

  megm_ram #(
    .WIDTH(MARK_W),
    .DEPTH(CELLS)
  ) u_marks (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ahead_addr),
    .rdata(ram_rdata)
  );

  always_comb begin
    ahead_ok  = 1'b0;
    ahead_row = row_r;
    ahead_col = col_r;
    case (head_r)
      HEAD_NORTH: begin
        ahead_ok  = (row_r != '0);
        ahead_row = row_r - ROW_W'(1);
      end
      HEAD_EAST: begin
        ahead_ok  = (int'(col_r) + 1 < GRID_COLS);
        ahead_col = col_r + COL_W'(1);
      end
      HEAD_SOUTH: begin
        ahead_ok  = (int'(row_r) + 1 < GRID_ROWS);
        ahead_row = row_r + ROW_W'(1);
      end
      default: begin
        ahead_ok  = (col_r != '0);
        ahead_col = col_r - COL_W'(1);
      end
    endcase
  end

  assign ahead_addr = cell_addr(ahead_row, ahead_col);
  assign pos_addr   = cell_addr(row_r, col_r);
  assign inc_vc     = (vc_r < MARK_MAX) ? vc_r + MARK_W'(1) : vc_r;
  assign mark_vc    = bt_r ? ((vc_r == '0) ? vc_r : vc_r - MARK_W'(1)) : inc_vc;
  assign mark_val   = bt_r ? MARK_DEAD : inc_vc;
  assign moved_inc  = (moved_r == '1) ? moved_r : moved_r + MOVE_W'(1);
  assign rem_sh     = {rem_r, quo_r[TIME_W-1]};
  assign rem_ge     = rem_sh >= {1'b0, seg_time};
  assign quo_new    = {quo_r[TIME_W-2:0], rem_ge};
  assign emit_go    = ~ov_r | ~out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == ADDR_W'(CELLS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (!q_empty) state_nxt = done_r ? ST_EMIT : ST_DIV;
      end
      ST_DIV: begin
        if (div_cnt_r == '1) state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (steps_r == '0) begin
          state_nxt = ST_DECIDE;
        end else if (!ahead_ok) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_DECIDE: begin
        if (item_r.finish || (item_r.turn == TURN_STRAIGHT && !ahead_ok)) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_nxt = (bt_r && ahead_ok) ? ST_CHECK : ST_EMIT;
      end
      ST_CHECK: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_go) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos_addr;
    ram_wdata = mark_val;
    q_pop     = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        q_pop = ~q_empty;
      end
      ST_WALK: begin
        ram_we    = (steps_r != '0) & ahead_ok;
        ram_waddr = ahead_addr;
      end
      ST_DECIDE: begin
        if (!item_r.finish && item_r.turn == TURN_BACK) begin
          ram_we    = 1'b1;
          ram_wdata = MARK_DEAD;
        end else if (!item_r.finish && item_r.turn == TURN_STRAIGHT) begin
          ram_we    = ahead_ok;
          ram_waddr = ahead_addr;
        end
      end
      ST_CHECK: begin
        ram_we    = (ram_rdata == '0);
        ram_wdata = inc_vc;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    clr_nxt      = clr_r;
    item_nxt     = item_r;
    rem_nxt      = rem_r;
    quo_nxt      = quo_r;
    div_cnt_nxt  = div_cnt_r;
    steps_nxt    = steps_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    head_nxt     = head_r;
    vc_nxt       = vc_r;
    bt_nxt       = bt_r;
    done_nxt     = done_r;
    moved_nxt    = moved_r;
    status_nxt   = status_r;
    turn_nxt     = turn_r;
    ov_nxt       = ov_r & out_stall;
    o_row_nxt    = o_row_r;
    o_col_nxt    = o_col_r;
    o_head_nxt   = o_head_r;
    o_turn_nxt   = o_turn_r;
    o_moved_nxt  = o_moved_r;
    o_status_nxt = o_status_r;
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + ADDR_W'(1);
      end
      ST_IDLE: begin
        if (!q_empty) begin
          item_nxt    = q_item;
          quo_nxt     = q_item.elapsed;
          rem_nxt     = '0;
          div_cnt_nxt = '0;
          moved_nxt   = '0;
          turn_nxt    = TURN_STRAIGHT;
          status_nxt  = done_r ? STAT_IGNORED : STAT_OK;
        end
      end
      ST_DIV: begin
        rem_nxt     = rem_ge ? TIME_W'(rem_sh - {1'b0, seg_time}) : TIME_W'(rem_sh);
        quo_nxt     = quo_new;
        div_cnt_nxt = div_cnt_r + 4'd1;
        if (div_cnt_r == '1) begin
          steps_nxt = (seg_time == '0 || quo_new == '0) ? '0 : quo_new - TIME_W'(1);
        end
      end
      ST_WALK: begin
        if (steps_r != '0) begin
          if (ahead_ok) begin
            row_nxt   = ahead_row;
            col_nxt   = ahead_col;
            vc_nxt    = mark_vc;
            moved_nxt = moved_inc;
            steps_nxt = steps_r - TIME_W'(1);
          end else begin
            status_nxt = STAT_OFFGRID;
          end
        end
      end
      ST_DECIDE: begin
        if (item_r.finish) begin
          done_nxt   = 1'b1;
          status_nxt = STAT_FINISH;
        end else begin
          turn_nxt = item_r.turn;
          case (item_r.turn)
            TURN_LEFT:  head_nxt = head_r + 2'd3;
            TURN_RIGHT: head_nxt = head_r + 2'd1;
            TURN_BACK: begin
              head_nxt = head_r + 2'd2;
              bt_nxt   = 1'b1;
            end
            default: begin
              if (ahead_ok) begin
                row_nxt   = ahead_row;
                col_nxt   = ahead_col;
                vc_nxt    = mark_vc;
                moved_nxt = moved_inc;
              end else begin
                status_nxt = STAT_OFFGRID;
              end
            end
          endcase
        end
      end
      ST_CHECK: begin
        if (ram_rdata == '0) begin
          bt_nxt = 1'b0;
          vc_nxt = inc_vc;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          ov_nxt       = 1'b1;
          o_row_nxt    = row_r;
          o_col_nxt    = col_r;
          o_head_nxt   = head_r;
          o_turn_nxt   = turn_r;
          o_moved_nxt  = moved_r;
          o_status_nxt = status_r;
        end
      end
      default: begin
        clr_nxt = clr_r;
      end
    endcase
    if (ld.ld_row)  row_nxt  = clamp_row(ld.row);
    if (ld.ld_col)  col_nxt  = clamp_col(ld.col);
    if (ld.ld_head) head_nxt = ld.head;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      row_r   <= clamp_row(RST_START_ROW);
      col_r   <= clamp_col(RST_START_COL);
      head_r  <= RST_START_HEAD;
      vc_r    <= '0;
      bt_r    <= 1'b0;
      done_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      head_r  <= head_nxt;
      vc_r    <= vc_nxt;
      bt_r    <= bt_nxt;
      done_r  <= done_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    div_cnt_r  <= div_cnt_nxt;
    steps_r    <= steps_nxt;
    moved_r    <= moved_nxt;
    status_r   <= status_nxt;
    turn_r     <= turn_nxt;
    o_row_r    <= o_row_nxt;
    o_col_r    <= o_col_nxt;
    o_head_r   <= o_head_nxt;
    o_turn_r   <= o_turn_nxt;
    o_moved_r  <= o_moved_nxt;
    o_status_r <= o_status_nxt;
  end

  assign clearing           = (state_r == ST_CLEAR);
  assign out_valid          = ov_r;
  assign out_row_now        = o_row_r;
  assign out_col_now        = o_col_r;
  assign out_heading_now    = o_head_r;
  assign out_chosen_turn    = o_turn_r;
  assign out_cells_advanced = o_moved_r;
  assign out_status         = o_status_r;

`ifndef ASSERT_OFF
  a_finish_status: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> status_r == STAT_FINISH)
    else $error("done set without finish status");

  a_bt_exit_mark: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(bt_r) |-> $past(ram_we) && $past(ram_wdata) != MARK_DEAD)
    else $error("backtrack cleared without a visit mark");

  a_walk_offgrid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK && steps_r != '0 && !ahead_ok) |=> state_r == ST_EMIT)
    else $error("walk continued past grid edge");

  a_pos_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    int'(row_r) < GRID_ROWS && int'(col_r) < GRID_COLS)
    else $error("position outside grid");
`endif

endmodule

### rtl/maze_explorer_grid_mapper_unit.sv
// Left-hand wall follower that maps a maze grid, one junction request at a time.
// After reset all 512 cells of the mark memory are cleared while in_stall is
// held high; configuration writes are taken during that pass. A request is then
// popped, its elapsed time is divided by segment time, the cells before the
// junction are walked (at most one grid span, 31 cells), the turn is decided,
// and a backtrack reads the cell ahead when there is one. A finish, an off-grid
// stop or a request ignored after the finish ends sooner. The one-bit-per-cycle
// division and the single write port of the mark memory, one cell per cycle,
// set the length of these steps. A finished result waits in the output register
// for as long as out_stall is held, and the next result waits behind it.
// A two-entry request queue and the output register let the input side keep
// accepting while a result waits to be taken, until the queue is full.
module maze_explorer_grid_mapper_unit
  import megm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CDATA_W-1:0] cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [TIME_W-1:0]  in_elapsed_ms,
  input  logic [LEVEL_W-1:0] in_far_left_level,
  input  logic [LEVEL_W-1:0] in_far_right_level,
  input  logic [LEVEL_W-1:0] in_mid_left_level,
  input  logic [LEVEL_W-1:0] in_center_level,
  input  logic [LEVEL_W-1:0] in_mid_right_level,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ROW_W-1:0]   out_row_now,
  output logic [COL_W-1:0]   out_col_now,
  output logic [1:0]         out_heading_now,
  output logic [1:0]         out_chosen_turn,
  output logic [MOVE_W-1:0]  out_cells_advanced,
  output logic [1:0]         out_status
);

  logic [LEVEL_W-1:0] side_thr_r;
  logic [LEVEL_W-1:0] fwd_thr_r;
  logic [LEVEL_W-1:0] fin_thr_r;
  logic [TIME_W-1:0]  seg_r;
  megm_ld_t           ld;
  logic               clearing;
  logic               q_full;
  logic               q_push;
  logic               q_pop;
  logic               q_empty;
  megm_item_t         push_item;
  megm_item_t         pop_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_thr_r <= RST_SIDE_THR;
      fwd_thr_r  <= RST_FWD_THR;
      fin_thr_r  <= RST_FIN_THR;
      seg_r      <= RST_SEG_TIME;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SIDE_THR: side_thr_r <= cfg_wdata[LEVEL_W-1:0];
        CFG_FWD_THR:  fwd_thr_r  <= cfg_wdata[LEVEL_W-1:0];
        CFG_FIN_THR:  fin_thr_r  <= cfg_wdata[LEVEL_W-1:0];
        CFG_SEG_TIME: seg_r      <= cfg_wdata[TIME_W-1:0];
        default:      seg_r      <= seg_r;
      endcase
    end
  end

  always_comb begin
    ld.ld_row  = cfg_we & (cfg_index == CFG_START_ROW);
    ld.ld_col  = cfg_we & (cfg_index == CFG_START_COL);
    ld.ld_head = cfg_we & (cfg_index == CFG_START_HEAD);
    ld.row     = cfg_wdata[ROW_W-1:0];
    ld.col     = cfg_wdata[COL_W-1:0];
    ld.head    = cfg_wdata[1:0];
  end

  megm_front u_front (
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_elapsed_ms     (in_elapsed_ms),
    .in_far_left_level (in_far_left_level),
    .in_far_right_level(in_far_right_level),
    .in_mid_left_level (in_mid_left_level),
    .in_center_level   (in_center_level),
    .in_mid_right_level(in_mid_right_level),
    .side_thr          (side_thr_r),
    .fwd_thr           (fwd_thr_r),
    .fin_thr           (fin_thr_r),
    .clearing          (clearing),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_item            (push_item)
  );

  megm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_item(push_item),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_item (pop_item)
  );

  megm_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .ld                (ld),
    .seg_time          (seg_r),
    .q_empty           (q_empty),
    .q_item            (pop_item),
    .q_pop             (q_pop),
    .clearing          (clearing),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_row_now       (out_row_now),
    .out_col_now       (out_col_now),
    .out_heading_now   (out_heading_now),
    .out_chosen_turn   (out_chosen_turn),
    .out_cells_advanced(out_cells_advanced),
    .out_status        (out_status)
  );

endmodule
